@@ rtl/core/argb_source_over_blend_core_macros.svh @@
// Assertion macros used by the checker of the blend core.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ARGB_SOURCE_OVER_BLEND_CORE_MACROS_SVH
`define ARGB_SOURCE_OVER_BLEND_CORE_MACROS_SVH

// Same-cycle implication.
`define ASOB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("asob assertion failed");

// Next-cycle implication.
`define ASOB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("asob assertion failed");

`endif

@@ rtl/core/asob_pkg.sv @@
package asob_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned NCH    = 3;
	localparam int unsigned PROD_W = 16;
	localparam int unsigned D_W    = 16;
	localparam int unsigned NUM_W  = 24;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;
	localparam logic [CHAN_W-1:0] CHAN_MIN = 8'h00;

	// Products formed in the first stage. Channel 0 is blue, 1 green, 2 red.
	typedef struct packed {
		logic                            byp;
		logic [31:0]                     byp_px;
		logic [CHAN_W-1:0]               da;
		logic [CHAN_W-1:0]               sa;
		logic [PROD_W-1:0]               dasa;
		logic [NCH-1:0][PROD_W-1:0]      dcda;
		logic [NCH-1:0][PROD_W-1:0]      sasc;
	} prod_t;

	// State of the shared restoring division, one remainder per channel.
	typedef struct packed {
		logic                            byp;
		logic [31:0]                     byp_px;
		logic [CHAN_W-1:0]               alpha;
		logic [NUM_W-1:0]                dsh;
		logic [NCH-1:0][NUM_W-1:0]       rem;
		logic [NCH-1:0][CHAN_W-1:0]      quo;
	} div_t;

endpackage

@@ rtl/core/asob_prod.sv @@
module asob_prod (
	input  logic           clk,
	input  logic           en,
	input  logic [31:0]    dst_argb,
	input  logic [31:0]    src_argb,
	output asob_pkg::prod_t prod_s1
);
	import asob_pkg::*;

	prod_t nxt;

	always_comb begin
		logic [CHAN_W-1:0] da;
		logic [CHAN_W-1:0] sa;
		logic [CHAN_W-1:0] dc;
		logic [CHAN_W-1:0] sc;
		da = dst_argb[31:24];
		sa = src_argb[31:24];
		nxt.da = da;
		nxt.sa = sa;
		nxt.dasa = PROD_W'(da) * PROD_W'(sa);
		if ((da == CHAN_MIN) || (sa == CHAN_MAX)) begin
			nxt.byp = 1'b1;
			nxt.byp_px = src_argb;
		end else if (sa == CHAN_MIN) begin
			nxt.byp = 1'b1;
			nxt.byp_px = dst_argb;
		end else begin
			nxt.byp = 1'b0;
			nxt.byp_px = src_argb;
		end
		for (int i = 0; i < NCH; i++) begin
			dc = dst_argb[8*i +: 8];
			sc = src_argb[8*i +: 8];
			nxt.dcda[i] = PROD_W'(dc) * PROD_W'(da);
			nxt.sasc[i] = PROD_W'(sc) * PROD_W'(sa);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= nxt;
		end
	end

endmodule

@@ rtl/core/asob_num.sv @@
module asob_num (
	input  logic            clk,
	input  logic            en,
	input  asob_pkg::prod_t prod_s1,
	output asob_pkg::div_t  div_s2
);
	import asob_pkg::*;

	div_t nxt;

	always_comb begin
		logic [8:0]        asum;
		logic [16:0]       s255;
		logic [16:0]       d17;
		logic [D_W-1:0]    d;
		logic [16:0]       a17;
		logic [CHAN_W-1:0] inv_sa;
		logic [NUM_W-1:0]  dpart;
		logic [NUM_W-1:0]  spart;
		asum   = {1'b0, prod_s1.da} + {1'b0, prod_s1.sa};
		s255   = {asum, 8'b0} - {8'b0, asum};
		d17    = s255 - {1'b0, prod_s1.dasa};
		d      = d17[D_W-1:0];
		// Exact truncating division by 255 into eight bits for any d up to 65279; d here is at most 65025.
		a17    = {1'b0, d} + {9'b0, d[15:8]} + 17'd1;
		inv_sa = CHAN_MAX - prod_s1.sa;
		nxt.byp    = prod_s1.byp;
		nxt.byp_px = prod_s1.byp_px;
		nxt.alpha  = a17[15:8];
		nxt.dsh    = {1'b0, d, 7'b0};
		for (int i = 0; i < NCH; i++) begin
			dpart = NUM_W'(prod_s1.dcda[i]) * NUM_W'(inv_sa);
			spart = {prod_s1.sasc[i], 8'b0} - {8'b0, prod_s1.sasc[i]};
			nxt.rem[i] = dpart + spart;
			nxt.quo[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s2 <= nxt;
		end
	end

endmodule

@@ rtl/core/asob_div.sv @@
module asob_div (
	input  logic           clk,
	input  logic           en,
	input  asob_pkg::div_t div_in,
	output asob_pkg::div_t div_out
);
	import asob_pkg::*;

	div_t nxt;
	div_t div_sk;

	// Two quotient bits per stage: compare against the shifted divisor,
	// subtract when it fits, then halve the divisor.
	always_comb begin
		logic take;
		nxt = div_in;
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < NCH; i++) begin
				take = (nxt.rem[i] >= nxt.dsh);
				if (take) begin
					nxt.rem[i] = nxt.rem[i] - nxt.dsh;
				end
				nxt.quo[i] = {nxt.quo[i][CHAN_W-2:0], take};
			end
			nxt.dsh = {1'b0, nxt.dsh[NUM_W-1:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_sk <= nxt;
		end
	end

	assign div_out = div_sk;

endmodule

@@ rtl/core/argb_source_over_blend_core.sv @@
// Channel  Handshake              Payload
// in       in_valid / in_stall    dst_argb[31:0], src_argb[31:0]
// out      out_valid / out_stall  out_argb[31:0]
//
// Six register stages: products, numerators and alpha, then four division
// stages that each resolve two quotient bits for all three color channels.
// One transaction enters per cycle when there are no stalls.
// Reset clears the stage valid bits only.
// A stall holds only the unbroken run of full stages at the output end, so bubbles still close up.
module argb_source_over_blend_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] dst_argb,
	input  logic [31:0] src_argb,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_argb
);
	import asob_pkg::*;

	localparam int unsigned NSTG = 6;

	logic [NSTG:1]   v_s;
	logic [NSTG+1:1] en;
	logic [NSTG:1]   v_in;

	prod_t prod_s1;
	div_t  div_s2;
	div_t  div_s3;
	div_t  div_s4;
	div_t  div_s5;
	div_t  div_s6;

	always_comb begin
		en[NSTG+1] = !out_stall;
		for (int k = NSTG; k >= 1; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign v_in = {v_s[NSTG-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (en[k]) begin
					v_s[k] <= v_in[k];
				end
			end
		end
	end

	asob_prod u_prod (
		.clk      (clk),
		.en       (en[1]),
		.dst_argb (dst_argb),
		.src_argb (src_argb),
		.prod_s1  (prod_s1)
	);

	asob_num u_num (
		.clk     (clk),
		.en      (en[2]),
		.prod_s1 (prod_s1),
		.div_s2  (div_s2)
	);

	asob_div u_div3 (.clk(clk), .en(en[3]), .div_in(div_s2), .div_out(div_s3));
	asob_div u_div4 (.clk(clk), .en(en[4]), .div_in(div_s3), .div_out(div_s4));
	asob_div u_div5 (.clk(clk), .en(en[5]), .div_in(div_s4), .div_out(div_s5));
	asob_div u_div6 (.clk(clk), .en(en[6]), .div_in(div_s5), .div_out(div_s6));

	assign in_stall  = !en[1];
	assign out_valid = v_s[NSTG];
	assign out_argb  = div_s6.byp ? div_s6.byp_px
		: {div_s6.alpha, div_s6.quo[2], div_s6.quo[1], div_s6.quo[0]};

endmodule

@@ rtl/core/asob_checker.sv @@
`include "argb_source_over_blend_core_macros.svh"

module asob_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [31:0] src_argb,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] out_argb
);
	// Counts consecutive edges at which the output side let data move.
	logic [2:0] flow_q;
	logic       flow6;
	logic       acc_in;
	logic       opaque_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_q <= '0;
		end else if (out_stall) begin
			flow_q <= '0;
		end else if (flow_q != 3'd7) begin
			flow_q <= flow_q + 3'd1;
		end
	end

	assign flow6     = (flow_q >= 3'd5);
	assign acc_in    = arst_n && in_valid && !in_stall;
	assign opaque_in = (src_argb[31:24] == 8'hff);

	`ASOB_ASSERT_IMP(a_stall_back, in_stall, out_valid && out_stall)
	`ASOB_ASSERT_IMP(a_latency, flow6 && $past(acc_in, 6), out_valid)
	`ASOB_ASSERT_IMP(a_opaque, flow6 && $past(acc_in && opaque_in, 6), out_argb == $past(src_argb, 6))
	`ASOB_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_argb))

endmodule

bind argb_source_over_blend_core asob_checker u_asob_checker (.*);
